// ----- design/hftp_pkg.sv -----
// ----------------------------------------------------------------------------
// hftp_pkg
// Widths, stage types and the arctangent table for the bearing pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hftp_pkg;

  localparam int CORDIC_STEPS        = 24;
  localparam int ANGLE_FRACTION_BITS = 10;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PRE_SHIFT = 24;
  localparam int Z_BITS    = 24;
  localparam int XY_W      = DIFF_W + PRE_SHIFT + 3;
  localparam int Z_W       = 34;
  localparam int SHIFT_W   = $clog2(CORDIC_STEPS);
  localparam int BEARING_W = 19;

  localparam int FULL_ANG  = 360 << ANGLE_FRACTION_BITS;
  localparam int RIGHT_ANG = 90 << ANGLE_FRACTION_BITS;
  localparam int ANG_W     = $clog2(FULL_ANG + 1);
  localparam int RND_SHIFT = Z_BITS - ANGLE_FRACTION_BITS;

  localparam logic [63:0] DEG_PER_RAD_Q48 = 64'd16127328204063728;

  typedef logic signed [Z_W-1:0] atan_tab_t [CORDIC_STEPS];

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   base90;
    logic                   neg;
    logic                   zero;
  } cordic_t;

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t          tab;
    logic [63:0]        term;
    logic signed [63:0] acc;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        tab[i] = Z_W'(45 << Z_BITS);
      end else begin
        acc = '0;
        for (int j = 0; (2 * j + 1) * i < 63; j++) begin
          term = (DEG_PER_RAD_Q48 >> ((2 * j + 1) * i)) / 64'(2 * j + 1);
          if (j % 2 == 1) begin
            acc = acc - $signed(term);
          end else begin
            acc = acc + $signed(term);
          end
        end
        tab[i] = Z_W'((acc + 64'sd8388608) >>> 24);
      end
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

endpackage

`default_nettype wire

// ----- design/hftp_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// hftp_cordic_stage
// One registered CORDIC vectoring rotation with its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hftp_cordic_stage
  import hftp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic [SHIFT_W-1:0]    shift_i,
  input  wire logic signed [Z_W-1:0] angle_i,
  input  wire logic                  valid_i,
  input  wire cordic_t               data_i,
  output logic                       valid_o,
  output cordic_t                    data_o
);

  logic    valid_q;
  cordic_t data_q, data_d;
  logic signed [XY_W-1:0] xs, ys;

  assign xs = data_i.x >>> shift_i;
  assign ys = data_i.y >>> shift_i;

  always_comb begin
    data_d = data_i;
    if (!data_i.y[XY_W-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + angle_i;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- design/heading_from_two_points.sv -----
// ----------------------------------------------------------------------------
// heading_from_two_points
// Bearing of the vector from a start point to an end point, by a pipelined
// CORDIC in vectoring mode.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while in_ready_o is high and returns
// one result per request, in order, through its stages: one stage forms the
// difference, one folds it into the first quadrant, one stage per CORDIC
// rotation, one clamps and rounds, one applies the west half-plane mirror.
// Bubbles close up under a stall, so requests are still taken while a
// finished result waits, as long as the pipeline holds a bubble. The bearing
// is in 1/2^10 degree, zero along +y and clockwise; start equal to end
// reports 90 degrees with zero_vector_o set.
`default_nettype none

module heading_from_two_points
  import hftp_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [COORD_W-1:0] start_x_i,
  input  wire logic signed [COORD_W-1:0] start_y_i,
  input  wire logic signed [COORD_W-1:0] end_x_i,
  input  wire logic signed [COORD_W-1:0] end_y_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [BEARING_W-1:0]           bearing_o,
  output logic                           zero_vector_o
);

  // difference stage
  logic                     dif_v_q, dif_en;
  logic signed [DIFF_W-1:0] dx_q, dy_q;

  // pipeline control
  logic                     pre_en, fin_en, out_en;
  logic                     cor_v [CORDIC_STEPS+1];
  cordic_t                  cor   [CORDIC_STEPS+1];
  logic                     cor_en [CORDIC_STEPS];

  // fold stage
  cordic_t                  pre_d, pre_q;
  logic                     pre_v_q;
  logic signed [DIFF_W-1:0] adx;

  // clamp and round stage
  logic                     fin_v_q;
  logic [ANG_W-1:0]         ang_q, ang_d;
  logic                     fin_neg_q, fin_zero_q;
  logic signed [Z_W-1:0]    t_raw, t_clamp, t_rnd;

  // output stage
  logic                     out_v_q;
  logic [BEARING_W-1:0]     bearing_q, bearing_d;
  logic                     zero_q;
  logic [ANG_W-1:0]         mirror;

  assign out_en     = !out_v_q || out_ready_i;
  assign fin_en     = !fin_v_q || out_en;
  assign pre_en     = !cor_v[0] || cor_en[0];
  assign dif_en     = !dif_v_q || pre_en;
  assign in_ready_o = dif_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_v_q <= 1'b0;
      pre_v_q <= 1'b0;
      fin_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (dif_en) dif_v_q <= in_valid_i;
      if (pre_en) pre_v_q <= dif_v_q;
      if (fin_en) fin_v_q <= cor_v[CORDIC_STEPS];
      if (out_en) out_v_q <= fin_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dif_en) begin
      dx_q <= DIFF_W'(end_x_i) - DIFF_W'(start_x_i);
      dy_q <= DIFF_W'(end_y_i) - DIFF_W'(start_y_i);
    end
  end

  assign adx = dx_q[DIFF_W-1] ? -dx_q : dx_q;

  always_comb begin
    pre_d.z      = '0;
    pre_d.neg    = dx_q[DIFF_W-1];
    pre_d.zero   = (dx_q == '0) && (dy_q == '0);
    pre_d.base90 = dy_q[DIFF_W-1];
    if (!dy_q[DIFF_W-1]) begin
      pre_d.x = XY_W'(dy_q) <<< PRE_SHIFT;
      pre_d.y = XY_W'(adx) <<< PRE_SHIFT;
    end else begin
      pre_d.x = XY_W'(adx) <<< PRE_SHIFT;
      pre_d.y = XY_W'(-dy_q) <<< PRE_SHIFT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pre_en) begin
      pre_q <= pre_d;
    end
  end

  assign cor_v[0] = pre_v_q;
  assign cor[0]   = pre_q;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    if (k == CORDIC_STEPS - 1) begin : g_last
      assign cor_en[k] = !cor_v[k+1] || fin_en;
    end else begin : g_mid
      assign cor_en[k] = !cor_v[k+1] || cor_en[k+1];
    end

    hftp_cordic_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (cor_en[k]),
      .shift_i (SHIFT_W'(k)),
      .angle_i (ATAN_TAB[k]),
      .valid_i (cor_v[k]),
      .data_i  (cor[k]),
      .valid_o (cor_v[k+1]),
      .data_o  (cor[k+1])
    );
  end

  always_comb begin
    t_raw = cor[CORDIC_STEPS].z;
    if (cor[CORDIC_STEPS].base90) begin
      t_raw = cor[CORDIC_STEPS].z + (Z_W'(90) <<< Z_BITS);
    end
    if (t_raw[Z_W-1]) begin
      t_clamp = '0;
    end else if (t_raw > (Z_W'(180) <<< Z_BITS)) begin
      t_clamp = Z_W'(180) <<< Z_BITS;
    end else begin
      t_clamp = t_raw;
    end
    t_rnd = (t_clamp + (Z_W'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    ang_d = t_rnd[ANG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (fin_en) begin
      ang_q      <= ang_d;
      fin_neg_q  <= cor[CORDIC_STEPS].neg;
      fin_zero_q <= cor[CORDIC_STEPS].zero;
    end
  end

  assign mirror = ANG_W'(FULL_ANG) - ang_q;

  always_comb begin
    if (fin_zero_q) begin
      bearing_d = BEARING_W'(RIGHT_ANG);
    end else if (fin_neg_q && (ang_q != '0)) begin
      bearing_d = BEARING_W'(mirror);
    end else if (fin_neg_q) begin
      bearing_d = '0;
    end else begin
      bearing_d = BEARING_W'(ang_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      bearing_q <= bearing_d;
      zero_q    <= fin_zero_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign bearing_o     = bearing_q;
  assign zero_vector_o = zero_q;

endmodule

`default_nettype wire

// ----- design/hftp_checker.sv -----
// ----------------------------------------------------------------------------
// hftp_checker
// Port-level checks for the bearing pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hftp_checker
  import hftp_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic signed [COORD_W-1:0] start_x_i,
  input wire logic signed [COORD_W-1:0] start_y_i,
  input wire logic signed [COORD_W-1:0] end_x_i,
  input wire logic signed [COORD_W-1:0] end_y_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [BEARING_W-1:0]      bearing_o,
  input wire logic                      zero_vector_o
);

  a_stall_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("request refused while the output could drain");

  a_zero_is_right_angle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_vector_o) |-> (bearing_o == BEARING_W'(RIGHT_ANG)))
    else $error("zero vector without a 90 degree bearing");

  a_bearing_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((FULL_ANG >= (1 << BEARING_W)) || (int'(bearing_o) < FULL_ANG)))
    else $error("bearing at or beyond a full turn");

  a_result_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(bearing_o) && $stable(zero_vector_o)))
    else $error("stalled result changed");

  a_request_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(start_x_i) && $stable(start_y_i) &&
       $stable(end_x_i) && $stable(end_y_i)))
    else $error("waiting request changed");

endmodule

bind heading_from_two_points hftp_checker u_hftp_checker (.*);

`default_nettype wire
